// ===== design/etc_pkg.sv =====
// shared types, constants and helper functions of the encoder turn controller
package etc_pkg;

  localparam int FRAC_BITS = 16;

  // field and datapath widths
  localparam int CNT_W    = 32;
  localparam int TGT_W    = 24;
  localparam int SPD_W    = 7;
  localparam int DRV_W    = 8;
  localparam int DIST_W   = CNT_W + 1;
  localparam int LOOK_W   = CNT_W + 3;
  localparam int NUM_W    = LOOK_W + 9;
  localparam int MAG_W    = TGT_W + 1;
  localparam int REM_W    = TGT_W + 2;
  localparam int QUO_W    = FRAC_BITS + 1;
  localparam int P_W      = FRAC_BITS + 3;
  localparam int M_W      = P_W + 9;
  localparam int T_W      = M_W - FRAC_BITS;
  localparam int STEP_W   = $clog2(FRAC_BITS + 1);

  // configuration port
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam logic [2:0] REG_INIT_LEFT  = 3'd0;
  localparam logic [2:0] REG_INIT_RIGHT = 3'd1;
  localparam logic [2:0] REG_TARGET     = 3'd2;
  localparam logic [2:0] REG_SPEED      = 3'd3;
  localparam logic [2:0] REG_TURN_LEFT  = 3'd4;

  localparam logic [TGT_W-1:0] TARGET_RST = TGT_W'(256);
  localparam logic [SPD_W-1:0] SPEED_RST  = SPD_W'(50);

  // speed bands of the stop threshold, and the finishing speed
  localparam logic [SPD_W-1:0] SPD_BAND1 = SPD_W'(21);
  localparam logic [SPD_W-1:0] SPD_BAND2 = SPD_W'(42);
  localparam logic [SPD_W-1:0] SPD_BAND3 = SPD_W'(75);
  localparam logic [SPD_W-1:0] SPD_BAND4 = SPD_W'(100);
  localparam logic [SPD_W-1:0] SPD_FIN   = SPD_W'(65);

  localparam logic signed [P_W-1:0] STOP1 = P_W'((64'd1 << FRAC_BITS) / 10);
  localparam logic signed [P_W-1:0] STOP2 = P_W'((64'd2 << FRAC_BITS) / 10);
  localparam logic signed [P_W-1:0] STOP3 = P_W'((64'd3 << FRAC_BITS) / 10);
  localparam logic signed [P_W-1:0] STOP4 = P_W'((64'd4 << FRAC_BITS) / 10);
  localparam logic signed [P_W-1:0] STOP5 = P_W'((64'd5 << FRAC_BITS) / 10);

  // fraction saturation value (two) and unit in the product format
  localparam logic signed [P_W-1:0] P_SAT = P_W'(64'd2 << FRAC_BITS);
  localparam logic signed [M_W-1:0] ONE_M = M_W'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_LOOK,
    ST_NUM,
    ST_DIV,
    ST_MUL,
    ST_DONE,
    ST_HOLD
  } etc_state_e;

  function automatic logic signed [P_W-1:0] stop_thr(input logic [SPD_W-1:0] spd);
    priority if (spd < SPD_BAND1) return STOP1;
    else if (spd < SPD_BAND2) return STOP2;
    else if (spd < SPD_BAND3) return STOP3;
    else if (spd < SPD_BAND4) return STOP4;
    else return STOP5;
  endfunction

  // truncate a fixed point value toward zero to its integer part
  function automatic logic signed [T_W-1:0] trunc_int(input logic signed [M_W-1:0] v);
    logic signed [T_W-1:0] t;
    t = T_W'(v >>> FRAC_BITS);
    if (v[M_W-1] && (|v[FRAC_BITS-1:0])) t = t + T_W'(1);
    return t;
  endfunction

  function automatic logic signed [DRV_W-1:0] sat8(input logic signed [T_W-1:0] v);
    if (v > T_W'(127)) return DRV_W'(127);
    if (v < -T_W'(128)) return -DRV_W'(128);
    return DRV_W'(v);
  endfunction

endpackage

// ===== design/encoder_turn_controller_top.sv =====
// encoder turn controller: sequencer, shared restoring divider and output register
// Each encoder sample yields one result item. From acceptance a sample passes
// the states DIST, LOOK and NUM, which form distances, lookahead and the
// numerators of both wheels, then one shared restoring divider produces the
// FRAC_BITS+1 quotient bits of each wheel's remaining fraction in turn, MUL
// multiplies by speed and DONE picks the drives. Once the turn is finished a
// sample is answered from the HOLD state with zero drives and done set. A finished
// result waits in an output register while the next sample is taken. Any write to
// a valid register address restarts the turn (previous counts load from the
// initial counts, the correction and done flags clear); write only while the
// block is idle.
module encoder_turn_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // apb configuration port
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [etc_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [etc_pkg::DATA_W-1:0]  pwdata_i,
  output logic [etc_pkg::DATA_W-1:0]  prdata_o,
  output logic                        pready_o,
  // encoder samples
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [63:0]                 s_axis_tdata_i,  // left_count, right_count
  // motor commands
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [15:0]                 m_axis_tdata_o,  // left_drive, right_drive
  output logic [1:0]                  m_axis_tuser_o   // command_valid, done_res
);
  import etc_pkg::*;

  // configuration
  logic signed [CNT_W-1:0] init_left_q, init_right_q;
  logic [TGT_W-1:0]        target_q;
  logic [SPD_W-1:0]        speed_q;
  logic                    turn_left_q;

  // turn state
  logic signed [CNT_W-1:0] prev_q [2];
  logic                    corrected_q, finished_q;

  // sequencer and datapath
  etc_state_e              state_q, state_d;
  logic signed [CNT_W-1:0] cnt_q [2];
  logic [DIST_W-1:0]       dist_q [2];
  logic signed [DIST_W-1:0] delta_q [2];
  logic signed [LOOK_W-1:0] look_q [2];
  logic [MAG_W-1:0]        mag_q [2];
  logic                    neg_q [2];
  logic                    sat_q [2];
  logic signed [P_W-1:0]   p_q [2];
  logic signed [M_W-1:0]   m_q [2];
  logic [REM_W-1:0]        rem_q;
  logic [QUO_W-1:0]        quo_q;
  logic [STEP_W-1:0]       step_q;
  logic                    wsel_q;

  // output register
  logic                    out_valid_q;
  logic signed [DRV_W-1:0] out_left_q, out_right_q;
  logic                    out_cmd_q, out_done_q;

  logic                    in_acc, cfg_wr, cfg_hit, commit;
  logic [2:0]              cfg_idx;
  logic [TGT_W-1:0]        tgt;
  logic signed [CNT_W-1:0] init_w [2];

  assign pready_o        = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_idx         = paddr_i[4:2];
  assign cfg_wr          = psel_i && penable_i && pwrite_i && pready_o;
  assign cfg_hit         = cfg_wr && (cfg_idx <= REG_TURN_LEFT);
  assign commit          = ((state_q == ST_DONE) || (state_q == ST_HOLD)) &&
                           (!out_valid_q || m_axis_tready_i);
  assign tgt             = (target_q == '0) ? TGT_W'(1) : target_q;
  assign init_w[0]       = init_left_q;
  assign init_w[1]       = init_right_q;

  always_comb begin
    unique case (cfg_idx)
      REG_INIT_LEFT:  prdata_o = init_left_q;
      REG_INIT_RIGHT: prdata_o = init_right_q;
      REG_TARGET:     prdata_o = DATA_W'(target_q);
      REG_SPEED:      prdata_o = DATA_W'(speed_q);
      REG_TURN_LEFT:  prdata_o = DATA_W'(turn_left_q);
      default:        prdata_o = '0;
    endcase
  end

  // shared divider step: one quotient bit per cycle, first step without doubling
  logic [REM_W-1:0]        rem_src, rem_nxt;
  logic [REM_W:0]          trial;
  logic                    qbit;
  logic [QUO_W-1:0]        quo_full;
  logic signed [P_W-1:0]   p_div;

  always_comb begin
    rem_src  = (step_q == '0) ? REM_W'(mag_q[wsel_q]) : {rem_q[REM_W-2:0], 1'b0};
    trial    = {1'b0, rem_src} - (REM_W + 1)'(tgt);
    qbit     = !trial[REM_W];
    rem_nxt  = qbit ? trial[REM_W-1:0] : rem_src;
    quo_full = {quo_q[QUO_W-2:0], qbit};
    if (sat_q[wsel_q]) p_div = neg_q[wsel_q] ? -P_SAT : P_SAT;
    else if (neg_q[wsel_q]) p_div = -$signed(P_W'(quo_full));
    else p_div = $signed(P_W'(quo_full));
  end

  // numerator of the remaining fraction per wheel
  logic signed [NUM_W-1:0] num_w [2];
  logic signed [NUM_W-1:0] two_t;
  assign two_t = $signed(NUM_W'({tgt, 1'b0}));
  always_comb begin
    for (int w = 0; w < 2; w++) begin
      num_w[w] = $signed(NUM_W'(tgt)) - $signed({look_q[w][LOOK_W-1], look_q[w], 8'b0});
    end
  end

  // drive decision
  logic signed [P_W-1:0]   stop;
  logic                    go_fwd, go_rev, near_unit, at_target, corr_nxt, fin_nxt;
  logic signed [T_W-1:0]   spd_s, sl, sr, tl, tr;
  always_comb begin
    stop      = stop_thr(speed_q);
    go_fwd    = (p_q[0] > stop) || (p_q[1] > stop);
    go_rev    = (p_q[0] < -stop) || (p_q[1] < -stop);
    near_unit = (m_q[0] > -ONE_M) && (m_q[0] < ONE_M) &&
                (m_q[1] > -ONE_M) && (m_q[1] < ONE_M);
    spd_s     = $signed(T_W'(speed_q));
    tl        = trunc_int(m_q[0]);
    tr        = trunc_int(m_q[1]);
    corr_nxt  = corrected_q;
    if (go_fwd) begin
      sl = turn_left_q ? -spd_s : spd_s;
    end else if (go_rev) begin
      sl = turn_left_q ? spd_s : -spd_s;
    end else if (near_unit) begin
      corr_nxt = 1'b1;
      sl = turn_left_q ? T_W'(1) : -T_W'(1);
    end else begin
      sl = turn_left_q ? -tl : tl;
    end
    if (!go_fwd && !go_rev && !near_unit) sr = turn_left_q ? tr : -tr;
    else sr = -sl;
    at_target = (dist_q[0] == DIST_W'(target_q[TGT_W-1:8])) &&
                (dist_q[1] == DIST_W'(target_q[TGT_W-1:8]));
    fin_nxt   = 1'b0;
    if (at_target) begin
      if ((speed_q > SPD_FIN) && corr_nxt) begin
        corr_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end else if (speed_q < SPD_FIN) begin
        fin_nxt  = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = finished_q ? ST_HOLD : ST_DIST;
      ST_DIST: state_d = ST_LOOK;
      ST_LOOK: state_d = ST_NUM;
      ST_NUM:  state_d = ST_DIV;
      ST_DIV:  if ((step_q == STEP_W'(FRAC_BITS)) && wsel_q) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      ST_HOLD: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and turn state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_left_q  <= '0;
      init_right_q <= '0;
      target_q     <= TARGET_RST;
      speed_q      <= SPEED_RST;
      turn_left_q  <= 1'b1;
      prev_q[0]    <= '0;
      prev_q[1]    <= '0;
      corrected_q  <= 1'b0;
      finished_q   <= 1'b0;
    end else if (cfg_hit) begin
      unique case (cfg_idx)
        REG_INIT_LEFT:  init_left_q  <= pwdata_i;
        REG_INIT_RIGHT: init_right_q <= pwdata_i;
        REG_TARGET:     target_q     <= pwdata_i[TGT_W-1:0];
        REG_SPEED:      speed_q      <= pwdata_i[SPD_W-1:0];
        REG_TURN_LEFT:  turn_left_q  <= pwdata_i[0];
        default: ;
      endcase
      prev_q[0]   <= (cfg_idx == REG_INIT_LEFT) ? pwdata_i : init_left_q;
      prev_q[1]   <= (cfg_idx == REG_INIT_RIGHT) ? pwdata_i : init_right_q;
      corrected_q <= 1'b0;
      finished_q  <= 1'b0;
    end else if (commit && (state_q == ST_DONE)) begin
      prev_q[0]   <= cnt_q[0];
      prev_q[1]   <= cnt_q[1];
      corrected_q <= corr_nxt;
      finished_q  <= fin_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        cnt_q[0] <= s_axis_tdata_i[31:0];
        cnt_q[1] <= s_axis_tdata_i[63:32];
        step_q   <= '0;
        wsel_q   <= 1'b0;
      end
      ST_DIST: begin
        for (int w = 0; w < 2; w++) begin
          logic signed [DIST_W-1:0] diff;
          diff       = DIST_W'(cnt_q[w]) - DIST_W'(init_w[w]);
          dist_q[w]  <= diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
          delta_q[w] <= DIST_W'(cnt_q[w]) - DIST_W'(prev_q[w]);
        end
      end
      ST_LOOK: begin
        for (int w = 0; w < 2; w++) begin
          look_q[w] <= $signed(LOOK_W'(dist_q[w])) + LOOK_W'(delta_q[w]);
        end
      end
      ST_NUM: begin
        for (int w = 0; w < 2; w++) begin
          neg_q[w] <= num_w[w][NUM_W-1];
          sat_q[w] <= (num_w[w] >= two_t) || (num_w[w] <= -two_t);
          mag_q[w] <= num_w[w][NUM_W-1] ? MAG_W'(-num_w[w]) : MAG_W'(num_w[w]);
        end
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= quo_full;
        if (step_q == STEP_W'(FRAC_BITS)) begin
          p_q[wsel_q] <= p_div;
          step_q      <= '0;
          wsel_q      <= 1'b1;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
      ST_MUL: begin
        for (int w = 0; w < 2; w++) begin
          logic signed [P_W+7:0] prod;
          prod    = p_q[w] * $signed({1'b0, speed_q});
          m_q[w] <= M_W'(prod) + ONE_M;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      if ((state_q == ST_HOLD) || at_target) begin
        out_left_q  <= '0;
        out_right_q <= '0;
        out_cmd_q   <= 1'b0;
        out_done_q  <= (state_q == ST_HOLD) ? 1'b1 : fin_nxt;
      end else begin
        out_left_q  <= sat8(sl);
        out_right_q <= sat8(sr);
        out_cmd_q   <= 1'b1;
        out_done_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_right_q, out_left_q};
  assign m_axis_tuser_o  = {out_done_q, out_cmd_q};

  // a finished turn answers from the hold state only
  a_hold_when_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && finished_q) |=> (state_q == ST_HOLD))
    else $error("finished turn did not take the hold path");

  // a result waits while the output register is still occupied
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && m_axis_tvalid_o && !m_axis_tready_i) |=>
      (state_q == ST_DONE))
    else $error("result committed over an unread item");

  // a command item never reports the turn as done
  a_cmd_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("command issued on a finished turn");

  // the divider runs both wheels before the multiply step
  a_div_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> ($past(state_q) == ST_DIV) && $past(wsel_q))
    else $error("multiply step entered before both divisions");

endmodule

// ===== test/tb_encoder_turn_controller_top.sv =====
// testbench of the encoder turn controller: directed and random turns checked against a predictor
`timescale 1ns / 100ps

module tb_encoder_turn_controller_top;

  import etc_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam longint CNT_MAX = 64'sd2147483647;
  localparam longint CNT_MIN = -64'sd2147483648;
  localparam logic [2:0] REG_SPARE = 3'd7;
  localparam int WALK_ITEMS = 1150;

  typedef struct packed {
    logic [CNT_W-1:0] left_cnt;
    logic [CNT_W-1:0] right_cnt;
    logic             drain;
  } encoder_sample_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] left_drv;
    logic signed [DRV_W-1:0] right_drv;
    logic                    cmd;
    logic                    done;
  } motor_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel_i = 1'b0;
  logic                penable_i = 1'b0;
  logic                pwrite_i = 1'b0;
  logic [ADDR_W-1:0]   paddr_i = '0;
  logic [DATA_W-1:0]   pwdata_i = '0;
  logic [DATA_W-1:0]   prdata_o;
  logic                pready_o;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [63:0]         s_axis_tdata_i = '0;  // left_count, right_count
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [15:0]         m_axis_tdata_o;       // left_drive, right_drive
  logic [1:0]          m_axis_tuser_o;       // command_valid, done_res

  encoder_turn_controller_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of the configuration and turn state
  longint           cfg_init_left = 0;
  longint           cfg_init_right = 0;
  logic [TGT_W-1:0] cfg_target = TARGET_RST;
  logic [SPD_W-1:0] cfg_speed = SPEED_RST;
  logic             cfg_turn_left = 1'b1;
  longint           prv_left = 0;
  longint           prv_right = 0;
  logic             kicked = 1'b0;
  logic             turn_done = 1'b0;

  encoder_sample_t encoder_q[$];
  motor_cmd_t      expected_cmds[$];
  encoder_sample_t cur_sample;
  logic            src_busy = 1'b0;
  logic            src_burst = 1'b0;
  int              src_gap = 0;
  logic            sink_burst = 1'b0;
  int              sink_wait = 0;
  int              fault_cnt = 0;
  int              walk_items = 0;

  function automatic longint remain_frac(input longint cnt, input longint base,
                                         input longint prv, input longint tgt);
    longint gone, num;
    gone = cnt - base;
    if (gone < 0) gone = -gone;
    num = tgt - (gone + cnt - prv) * 256;
    if (num > 2 * tgt) return 2 * ONE;
    if (num < -2 * tgt) return -2 * ONE;
    return (num * ONE) / tgt;
  endfunction

  function automatic logic signed [DRV_W-1:0] drive_clamp(input longint v);
    if (v > 127) return 8'sd127;
    if (v < -128) return -8'sd128;
    return DRV_W'(v);
  endfunction

  function automatic motor_cmd_t predict_command(input logic signed [CNT_W-1:0] left_in,
                                                 input logic signed [CNT_W-1:0] right_in);
    motor_cmd_t res;
    longint lc, rc, tgt, dl, dr, pl, pr, halt_lvl, ls, rs, spd, sl, sr, ql, qr, tint;
    int band;
    res = '0;
    if (turn_done) begin
      res.done = 1'b1;
      return res;
    end
    lc = left_in;
    rc = right_in;
    tgt = (cfg_target == '0) ? 1 : longint'(cfg_target);
    spd = longint'(cfg_speed);
    ls = cfg_turn_left ? -1 : 1;
    rs = -ls;
    dl = lc - cfg_init_left;
    if (dl < 0) dl = -dl;
    dr = rc - cfg_init_right;
    if (dr < 0) dr = -dr;
    pl = remain_frac(lc, cfg_init_left, prv_left, tgt);
    pr = remain_frac(rc, cfg_init_right, prv_right, tgt);
    if (cfg_speed < SPD_BAND1) band = 1;
    else if (cfg_speed < SPD_BAND2) band = 2;
    else if (cfg_speed < SPD_BAND3) band = 3;
    else if (cfg_speed < SPD_BAND4) band = 4;
    else band = 5;
    halt_lvl = (band * ONE) / 10;
    if (pl > halt_lvl || pr > halt_lvl) begin
      sl = spd * ls;
      sr = spd * rs;
    end else if (pl < -halt_lvl || pr < -halt_lvl) begin
      sl = spd * rs;
      sr = spd * ls;
    end else begin
      ql = pl * spd * ls + ls * ONE;
      qr = pr * spd * rs + rs * ONE;
      // both drives under one: correction kick against the turn
      if (ql > -ONE && ql < ONE && qr > -ONE && qr < ONE) begin
        kicked = 1'b1;
        sl = rs;
        sr = ls;
      end else begin
        sl = ql / ONE;
        sr = qr / ONE;
      end
    end
    tint = longint'(cfg_target >> 8);
    if (dl == tint && dr == tint) begin
      if (cfg_speed > SPD_FIN && kicked) begin
        kicked = 1'b0;
        turn_done = 1'b1;
      end else if (cfg_speed < SPD_FIN) begin
        turn_done = 1'b1;
      end
    end else begin
      res.cmd = 1'b1;
      res.left_drv = drive_clamp(sl);
      res.right_drv = drive_clamp(sr);
    end
    prv_left = lc;
    prv_right = rc;
    res.done = turn_done;
    return res;
  endfunction

  // sample source
  always @(posedge clk_i) begin
    logic nxt_valid;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      src_gap = 0;
      src_busy = 1'b0;
    end else begin
      nxt_valid = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_cmds.push_back(predict_command(cur_sample.left_cnt, cur_sample.right_cnt));
        nxt_valid = 1'b0;
        src_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) src_burst = ~src_burst;
        src_gap = src_burst ? 0 : $urandom_range(0, 11);
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (encoder_q.size() != 0 &&
                     !(encoder_q[0].drain && expected_cmds.size() != 0)) begin
          cur_sample = encoder_q.pop_front();
          src_busy = 1'b1;
          nxt_valid = 1'b1;
          s_axis_tdata_i <= {cur_sample.right_cnt, cur_sample.left_cnt};
        end
      end
      s_axis_tvalid_i <= nxt_valid;
    end
  end

  // command sink and checker
  always @(posedge clk_i) begin
    motor_cmd_t want, got;
    logic nxt_ready;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_wait = 0;
    end else begin
      nxt_ready = m_axis_tready_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.left_drv = m_axis_tdata_o[7:0];
        got.right_drv = m_axis_tdata_o[15:8];
        got.cmd = m_axis_tuser_o[0];
        got.done = m_axis_tuser_o[1];
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected item, got %h/%h", $time, m_axis_tdata_o, m_axis_tuser_o);
          fault_cnt++;
        end else begin
          want = expected_cmds.pop_front();
          if (got.left_drv !== want.left_drv) begin
            $display("%0t: left_drive expected %0d got %0d", $time, want.left_drv, got.left_drv);
            fault_cnt++;
          end
          if (got.right_drv !== want.right_drv) begin
            $display("%0t: right_drive expected %0d got %0d", $time, want.right_drv,
                     got.right_drv);
            fault_cnt++;
          end
          if (got.cmd !== want.cmd) begin
            $display("%0t: command_valid expected %b got %b", $time, want.cmd, got.cmd);
            fault_cnt++;
          end
          if (got.done !== want.done) begin
            $display("%0t: done_res expected %b got %b", $time, want.done, got.done);
            fault_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) sink_burst = ~sink_burst;
        sink_wait = sink_burst ? 0 : $urandom_range(0, 11);
        nxt_ready = (sink_wait == 0);
      end else if (!m_axis_tready_i) begin
        if (sink_wait > 0) sink_wait--;
        nxt_ready = (sink_wait == 0);
      end
      m_axis_tready_i <= nxt_ready;
    end
  end

  task automatic queue_sample(input logic [CNT_W-1:0] lc, input logic [CNT_W-1:0] rc,
                              input logic drain);
    encoder_sample_t s;
    s.left_cnt = lc;
    s.right_cnt = rc;
    s.drain = drain;
    encoder_q.push_back(s);
  endtask

  task automatic wait_idle();
    while (encoder_q.size() != 0 || src_busy || expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    logic hit;
    hit = 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {idx, 2'b00};
    pwdata_i <= val;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    case (idx)
      REG_INIT_LEFT:  cfg_init_left = longint'(signed'(val));
      REG_INIT_RIGHT: cfg_init_right = longint'(signed'(val));
      REG_TARGET:     cfg_target = val[TGT_W-1:0];
      REG_SPEED:      cfg_speed = val[SPD_W-1:0];
      REG_TURN_LEFT:  cfg_turn_left = val[0];
      default:        hit = 1'b0;
    endcase
    // any known register restarts the turn
    if (hit) begin
      prv_left = cfg_init_left;
      prv_right = cfg_init_right;
      kicked = 1'b0;
      turn_done = 1'b0;
    end
  endtask

  task automatic setup_turn(input logic [31:0] il, input logic [31:0] ir,
                            input logic [TGT_W-1:0] tg, input logic [SPD_W-1:0] sp,
                            input logic tl);
    wait_idle();
    reg_write(REG_INIT_LEFT, il);
    reg_write(REG_INIT_RIGHT, ir);
    reg_write(REG_TARGET, 32'(tg));
    reg_write(REG_SPEED, 32'(sp));
    reg_write(REG_TURN_LEFT, 32'(tl));
  endtask

  function automatic longint next_offset(input longint off, input longint tint);
    longint hop;
    if (off > tint) begin
      hop = $urandom_range(1, 32'(off - tint));
      return off - hop;
    end
    if (off == tint) return off;
    // occasional overshoot past the target
    if ($urandom_range(0, 9) == 0) begin
      hop = $urandom_range(1, 3);
      return tint + hop;
    end
    hop = tint / 8 + 2;
    if (hop > tint - off) hop = tint - off;
    hop = $urandom_range(1, 32'(hop));
    return off + hop;
  endfunction

  task automatic random_turn();
    logic [31:0]      il, ir;
    logic [TGT_W-1:0] tg;
    logic [SPD_W-1:0] sp;
    longint           il_s, ir_s, tint, off_l, off_r, dir_l, dir_r;
    il = $urandom;
    ir = $urandom;
    if ($urandom_range(0, 15) == 0) begin
      il = 32'h7FFF_FFF0;
      ir = 32'h8000_0008;
    end
    case ($urandom_range(0, 19))
      0:       tg = '0;
      1:       tg = '1;
      2:       tg = TGT_W'(1);
      3:       tg = TGT_W'($urandom);
      default: tg = (TGT_W'($urandom_range(0, 40)) << 8) | TGT_W'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0:       sp = SPD_FIN;
      1:       sp = '0;
      2:       sp = '1;
      3:       sp = SPD_FIN - 1;
      4:       sp = SPD_FIN + 1;
      default: sp = SPD_W'($urandom_range(0, 127));
    endcase
    setup_turn(il, ir, tg, sp, 1'($urandom));
    il_s = longint'(signed'(il));
    ir_s = longint'(signed'(ir));
    tint = longint'(tg >> 8);
    dir_l = $urandom_range(0, 1) ? 1 : -1;
    dir_r = $urandom_range(0, 1) ? 1 : -1;
    if (il_s + dir_l * (tint + 8) > CNT_MAX || il_s + dir_l * (tint + 8) < CNT_MIN)
      dir_l = -dir_l;
    if (ir_s + dir_r * (tint + 8) > CNT_MAX || ir_s + dir_r * (tint + 8) < CNT_MIN)
      dir_r = -dir_r;
    off_l = 0;
    off_r = 0;
    // walk both wheels toward the target distance, with some noise
    while (off_l != tint || off_r != tint) begin
      off_l = next_offset(off_l, tint);
      off_r = next_offset(off_r, tint);
      queue_sample(CNT_W'(il_s + dir_l * off_l), CNT_W'(ir_s + dir_r * off_r),
                   $urandom_range(0, 49) == 0);
      walk_items++;
      if ($urandom_range(0, 11) == 0) begin
        queue_sample($urandom, $urandom, 1'b0);
        walk_items++;
      end
    end
    // linger at the target: finishing, held, or ignored after finish
    repeat (2) queue_sample(CNT_W'(il_s + dir_l * tint), CNT_W'(ir_s + dir_r * tint), 1'b0);
    walk_items += 2;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: extreme counts, finish, then an ignored item
    queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_sample(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    queue_sample(32'h0000_0000, 32'h0000_0000, 1'b0);

    // zero target at extreme initial counts, fast right turn, unused register
    setup_turn(32'h8000_0000, 32'h7FFF_FFFF, '0, '1, 1'b0);
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    queue_sample(32'h8000_0001, 32'h7FFF_FFFE, 1'b1);
    queue_sample(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);

    // speed at the finishing value: at target without a command
    setup_turn(32'h0, 32'h0, TGT_W'(768), SPD_FIN, 1'b1);
    queue_sample(32'd3, -32'sd3, 1'b0);
    queue_sample(32'd4, -32'sd4, 1'b0);
    queue_sample(32'd3, -32'sd3, 1'b0);

    // slight negative remainder gives a correction kick, then finish
    setup_turn(32'd1000, -32'sd1000, TGT_W'(1277), SPD_BAND4, 1'b1);
    queue_sample(32'd1003, -32'sd997, 1'b0);
    queue_sample(32'd1004, -32'sd996, 1'b0);
    queue_sample(32'd1010, -32'sd990, 1'b0);

    while (walk_items < WALK_ITEMS) random_turn();

    wait_idle();
    repeat (40) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("tb_encoder_turn_controller_top: clean");
    end else begin
      $display("tb_encoder_turn_controller_top: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_encoder_turn_controller_top: errors");
    $finish;
  end

endmodule
